FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checker: next-cycle implication failed");

`endif

FILE: src/tklpt_pkg.sv
package tklpt_pkg;

  // Table geometry: slot count is a power of two
  localparam int SLOT_BITS   = 16;
  localparam int TABLE_SLOTS = 1 << SLOT_BITS;
  localparam int MAX_PROBES  = 32;
  localparam int PROBE_W     = $clog2(MAX_PROBES) + 1;

  // Hash multipliers; only the low SLOT_BITS of each product reach the slot index
  localparam logic [31:0] HASH_K_ZOOM = 32'd2654435761;
  localparam logic [31:0] HASH_K_X    = 32'd40503;
  localparam logic [31:0] HASH_K_Y    = 32'd2246822519;

  localparam logic [31:0] DROP_MAX = 32'hFFFF_FFFF;

  // Operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // One table slot as stored in the memory
  typedef struct packed {
    logic        used;
    logic        present;
    logic [4:0]  zoom;
    logic [63:0] coords;
  } slot_entry_t;

endpackage

FILE: src/tile_key_linear_probe_table.sv
// Channel  | Ports                                                  | Direction
// ---------+--------------------------------------------------------+----------
// in       | in_valid, in_stall, in_func, in_zoom, in_tile_x,       | request
//          | in_tile_y, in_present_in                               |
// out      | out_valid, out_stall, out_found, out_present_out,      | result
//          | out_dropped, out_drop_total                            |
//
// From its transfer to its result an item goes through these steps, where P (1..MAX_PROBES)
// is the number of slots probed: three passes through the one shared hash multiplier, one
// memory read issue step, P probes at one per cycle through the registered read port, and
// a load of the output register. The next item is taken once the result is loaded.
// After reset a clearing pass writes all TABLE_SLOTS slots empty, with in_stall high throughout.
// A stalled result holds in the output register.
module tile_key_linear_probe_table
  import tklpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [4:0]  in_zoom,
  input  logic [31:0] in_tile_x,
  input  logic [31:0] in_tile_y,
  input  logic        in_present_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic        out_present_out,
  output logic        out_dropped,
  output logic [31:0] out_drop_total
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ISSUE,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    HS_ZOOM,
    HS_X,
    HS_Y
  } hash_step_t;

  state_t                 state_r, state_nxt;
  hash_step_t             hstep_r, hstep_nxt;
  logic [SLOT_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic [SLOT_BITS-1:0]   rd_addr_r, rd_addr_nxt;
  logic [SLOT_BITS-1:0]   cmp_addr_r;
  logic [SLOT_BITS-1:0]   hash_r, hash_nxt;
  logic [PROBE_W-1:0]     probe_cnt_r, probe_cnt_nxt;
  logic [31:0]            drop_cnt_r, drop_cnt_nxt;

  // Captured request
  logic                   func_r, func_nxt;
  logic [4:0]             zoom_r, zoom_nxt;
  logic [63:0]            coords_r, coords_nxt;
  logic                   pres_in_r, pres_in_nxt;

  // Pending result
  logic                   res_found_r, res_found_nxt;
  logic                   res_pres_r, res_pres_nxt;
  logic                   res_drop_r, res_drop_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic                   out_pres_r, out_pres_nxt;
  logic                   out_drop_r, out_drop_nxt;
  logic [31:0]            out_total_r, out_total_nxt;

  // Slot memory
  slot_entry_t            slot_mem_r [TABLE_SLOTS];
  slot_entry_t            rd_data_r;
  logic                   wr_en;
  logic [SLOT_BITS-1:0]   wr_addr;
  slot_entry_t            wr_data;

  // Shared multiplier, low half of the product only
  logic [SLOT_BITS-1:0]   mul_a, mul_b;
  logic [SLOT_BITS-1:0]   mul_p;

  logic                   slot_hit, slot_empty, probe_last;

  // Select multiplier operands for the current hash step
  always_comb begin
    case (hstep_r)
      HS_ZOOM: begin
        mul_a = SLOT_BITS'({27'd0, zoom_r});
        mul_b = HASH_K_ZOOM[SLOT_BITS-1:0];
      end
      HS_X: begin
        mul_a = coords_r[SLOT_BITS-1:0];
        mul_b = HASH_K_X[SLOT_BITS-1:0];
      end
      HS_Y: begin
        mul_a = coords_r[32 +: SLOT_BITS];
        mul_b = HASH_K_Y[SLOT_BITS-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Compare the slot read last cycle against the key
  assign slot_empty = !rd_data_r.used;
  assign slot_hit   = rd_data_r.used && (rd_data_r.zoom == zoom_r) &&
                      (rd_data_r.coords == coords_r);
  assign probe_last = (probe_cnt_r == PROBE_W'(MAX_PROBES - 1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    hstep_nxt     = hstep_r;
    clr_addr_nxt  = clr_addr_r;
    rd_addr_nxt   = rd_addr_r;
    hash_nxt      = hash_r;
    probe_cnt_nxt = probe_cnt_r;
    drop_cnt_nxt  = drop_cnt_r;
    func_nxt      = func_r;
    zoom_nxt      = zoom_r;
    coords_nxt    = coords_r;
    pres_in_nxt   = pres_in_r;
    res_found_nxt = res_found_r;
    res_pres_nxt  = res_pres_r;
    res_drop_nxt  = res_drop_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pres_nxt  = out_pres_r;
    out_drop_nxt  = out_drop_r;
    out_total_nxt = out_total_r;
    wr_en         = 1'b0;
    wr_addr       = cmp_addr_r;
    wr_data       = '{used: 1'b1, present: pres_in_r, zoom: zoom_r, coords: coords_r};

    // Drop the output once it transfers
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Sweep the table empty, one slot a cycle
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {SLOT_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_func;
          zoom_nxt    = in_zoom;
          coords_nxt  = {in_tile_y, in_tile_x};
          pres_in_nxt = in_present_in;
          hash_nxt    = '0;
          hstep_nxt   = HS_ZOOM;
          state_nxt   = ST_HASH;
        end
      end
      ST_HASH: begin
        // Fold one product per cycle into the slot index
        hash_nxt = hash_r ^ mul_p;
        case (hstep_r)
          HS_ZOOM: hstep_nxt = HS_X;
          HS_X:    hstep_nxt = HS_Y;
          default: begin
            rd_addr_nxt = hash_r ^ mul_p;
            state_nxt   = ST_ISSUE;
          end
        endcase
      end
      ST_ISSUE: begin
        // Home slot read is in flight; issue the next one behind it
        rd_addr_nxt   = rd_addr_r + 1'b1;
        probe_cnt_nxt = '0;
        state_nxt     = ST_PROBE;
      end
      ST_PROBE: begin
        rd_addr_nxt   = rd_addr_r + 1'b1;
        probe_cnt_nxt = probe_cnt_r + 1'b1;
        res_found_nxt = 1'b0;
        res_pres_nxt  = 1'b0;
        res_drop_nxt  = 1'b0;
        if (func_r == FUNC_INSERT) begin
          if (slot_empty || slot_hit) begin
            wr_en         = 1'b1;
            res_found_nxt = 1'b1;
            state_nxt     = ST_DONE;
          end else if (probe_last) begin
            res_drop_nxt = 1'b1;
            if (drop_cnt_r != DROP_MAX) begin
              drop_cnt_nxt = drop_cnt_r + 1'b1;
            end
            state_nxt = ST_DONE;
          end
        end else begin
          if (slot_hit) begin
            res_found_nxt = 1'b1;
            res_pres_nxt  = rd_data_r.present;
            state_nxt     = ST_DONE;
          end else if (slot_empty || probe_last) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pres_nxt  = res_pres_r;
          out_drop_nxt  = res_drop_r;
          out_total_nxt = drop_cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      drop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hstep_r     <= hstep_nxt;
    rd_addr_r   <= rd_addr_nxt;
    cmp_addr_r  <= rd_addr_r;
    hash_r      <= hash_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    func_r      <= func_nxt;
    zoom_r      <= zoom_nxt;
    coords_r    <= coords_nxt;
    pres_in_r   <= pres_in_nxt;
    res_found_r <= res_found_nxt;
    res_pres_r  <= res_pres_nxt;
    res_drop_r  <= res_drop_nxt;
    out_found_r <= out_found_nxt;
    out_pres_r  <= out_pres_nxt;
    out_drop_r  <= out_drop_nxt;
    out_total_r <= out_total_nxt;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem_r[rd_addr_r];
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_present_out = out_pres_r;
  assign out_dropped     = out_drop_r;
  assign out_drop_total  = out_total_r;

endmodule

FILE: src/tklpt_checker.sv
`include "assert_macros.svh"

module tklpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_func,
  input logic [4:0]  in_zoom,
  input logic [31:0] in_tile_x,
  input logic [31:0] in_tile_y,
  input logic        in_present_in,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic        out_present_out,
  input logic        out_dropped,
  input logic [31:0] out_drop_total
);

  // Result fields gathered for the hold check
  logic [34:0] out_fields;

  assign out_fields = {out_found, out_present_out, out_dropped, out_drop_total};

  // Hold a stalled result
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_fields))

  // A dropped insert never reports a written slot
  `CHK_IMP(a_drop_not_found, clk, rst_n, out_valid && out_dropped, !out_found)

  // A stored bit only comes back with a hit
  `CHK_IMP(a_pres_needs_hit, clk, rst_n, out_valid && out_present_out, out_found && !out_dropped)

  // A drop has always been counted
  `CHK_IMP(a_drop_counted, clk, rst_n, out_valid && out_dropped, out_drop_total != 32'd0)

  // Clearing pass follows reset
  `CHK_IMP(a_clear_after_reset, clk, rst_n, $past(rst_n) == 1'b0, in_stall)

endmodule

bind tile_key_linear_probe_table tklpt_checker u_tklpt_checker (.*);

FILE: tb/tb_tile_key_linear_probe_table.sv
`timescale 1ns / 1ps

module tb_tile_key_linear_probe_table;
  import tklpt_pkg::*;

  localparam int ITEM_COUNT   = 1150;
  localparam int N_FAMILIES   = 5;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [4:0]  zoom;
    logic [31:0] tile_x;
    logic [31:0] tile_y;
  } tile_key_t;

  typedef struct packed {
    logic      func;
    tile_key_t key;
    logic      present;
  } tile_req_t;

  typedef struct packed {
    logic        found;
    logic        present;
    logic        dropped;
    logic [31:0] drop_total;
  } tile_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = FUNC_LOOKUP;
  logic [4:0]  in_zoom = '0;
  logic [31:0] in_tile_x = '0;
  logic [31:0] in_tile_y = '0;
  logic        in_present_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic        out_present_out;
  logic        out_dropped;
  logic [31:0] out_drop_total;

  tile_key_linear_probe_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_zoom        (in_zoom),
    .in_tile_x      (in_tile_x),
    .in_tile_y      (in_tile_y),
    .in_present_in  (in_present_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_present_out(out_present_out),
    .out_dropped    (out_dropped),
    .out_drop_total (out_drop_total)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table
  bit          tbl_used    [TABLE_SLOTS];
  logic [4:0]  tbl_zoom    [TABLE_SLOTS];
  logic [63:0] tbl_coords  [TABLE_SLOTS];
  logic        tbl_present [TABLE_SLOTS];
  logic [31:0] drop_count = '0;

  tile_req_t    pending_reqs[$];
  tile_result_t expected_results[$];

  // Keys that share a home slot: fixed zoom and low halves, random high halves
  logic [4:0]  fam_zoom [N_FAMILIES];
  logic [15:0] fam_x_lo [N_FAMILIES];
  logic [15:0] fam_y_lo [N_FAMILIES];

  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  n_hits = 0;
  int  n_misses = 0;
  int  n_written = 0;
  int  n_dropped = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;

  function automatic logic [SLOT_BITS-1:0] home_slot_of(tile_key_t k);
    logic [63:0] h;
    h = ({59'd0, k.zoom} * {32'd0, HASH_K_ZOOM})
        ^ ({32'd0, k.tile_x} * {32'd0, HASH_K_X})
        ^ ({32'd0, k.tile_y} * {32'd0, HASH_K_Y});
    return h[SLOT_BITS-1:0];
  endfunction

  // Walk the shadow table for one request and update it
  function automatic tile_result_t probe_table(tile_req_t r);
    tile_result_t res;
    int unsigned  idx;
    logic         same_key;
    res = '0;
    idx = 32'(home_slot_of(r.key));
    for (int p = 0; p < MAX_PROBES; p++) begin
      same_key = tbl_used[idx] && tbl_zoom[idx] == r.key.zoom
                 && tbl_coords[idx] == {r.key.tile_y, r.key.tile_x};
      if (r.func == FUNC_LOOKUP) begin
        if (!tbl_used[idx]) break;
        if (same_key) begin
          res.found = 1'b1;
          res.present = tbl_present[idx];
          break;
        end
      end else if (!tbl_used[idx] || same_key) begin
        tbl_used[idx] = 1'b1;
        tbl_zoom[idx] = r.key.zoom;
        tbl_coords[idx] = {r.key.tile_y, r.key.tile_x};
        tbl_present[idx] = r.present;
        res.found = 1'b1;
        break;
      end
      idx = (idx + 1) % TABLE_SLOTS;
    end
    if (r.func == FUNC_INSERT && !res.found) begin
      res.dropped = 1'b1;
      if (drop_count != DROP_MAX) drop_count++;
      n_dropped++;
    end else if (r.func == FUNC_INSERT) begin
      n_written++;
    end else if (res.found) begin
      n_hits++;
    end else begin
      n_misses++;
    end
    res.drop_total = drop_count;
    return res;
  endfunction

  function automatic tile_key_t family_key(int f);
    tile_key_t   k;
    logic [31:0] rx;
    logic [31:0] ry;
    rx = $urandom;
    ry = $urandom;
    k.zoom = fam_zoom[f];
    k.tile_x = {rx[31:16], fam_x_lo[f]};
    k.tile_y = {ry[31:16], fam_y_lo[f]};
    return k;
  endfunction

  task automatic queue_req(input logic func, input tile_key_t k, input logic p);
    tile_req_t r;
    r.func = func;
    r.key = k;
    r.present = p;
    pending_reqs.push_back(r);
  endtask

  // Check results, then record accepted requests
  always @(posedge clk) begin
    tile_result_t want;
    tile_req_t    req;
    in_took <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          fail_count++;
        end
        if (out_present_out !== want.present) begin
          $error("present_out: expected %0d, got %0d", want.present, out_present_out);
          fail_count++;
        end
        if (out_dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, out_dropped);
          fail_count++;
        end
        if (out_drop_total !== want.drop_total) begin
          $error("drop_total: expected %0d, got %0d", want.drop_total, out_drop_total);
          fail_count++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      req.func = in_func;
      req.key.zoom = in_zoom;
      req.key.tile_x = in_tile_x;
      req.key.tile_y = in_tile_y;
      req.present = in_present_in;
      expected_results.push_back(probe_table(req));
      items_sent++;
    end
  end

  // Request driver: hold a stalled transfer, otherwise idle or offer the next item
  always @(negedge clk) begin
    tile_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        in_func <= nxt.func;
        in_zoom <= nxt.key.zoom;
        in_tile_x <= nxt.key.tile_x;
        in_tile_y <= nxt.key.tile_y;
        in_present_in <= nxt.present;
        in_valid <= 1'b1;
        gap_left = in_calm ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each transfer, two long holds to back up the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_took) begin
        if (results_seen == 300 || results_seen == 800) stall_left = LONG_HOLD;
        else stall_left = out_calm ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    tile_key_t   k;
    logic [15:0] target;
    int          r;
    int          total;
    logic [31:0] rnd;

    // Place families on chosen home slots; two straddle the wrap, two sit side by side
    for (int f = 0; f < N_FAMILIES; f++) begin
      fam_zoom[f] = 5'($urandom_range(0, 31));
      fam_y_lo[f] = 16'($urandom);
      case (f)
        0:       target = 16'hFFF0;
        1:       target = 16'hFFFA;
        2:       target = 16'd1000;
        3:       target = 16'd1012;
        default: target = 16'($urandom);
      endcase
      for (int v = 0; v < 65536; v++) begin
        k.zoom = fam_zoom[f];
        k.tile_x = 32'(v);
        k.tile_y = {16'd0, fam_y_lo[f]};
        if (home_slot_of(k) == target) fam_x_lo[f] = 16'(v);
      end
    end

    // Directed: all-ones key on an empty table, then write, read back and overwrite
    k = '{zoom: 5'd31, tile_x: 32'hFFFF_FFFF, tile_y: 32'hFFFF_FFFF};
    queue_req(FUNC_LOOKUP, k, 1'b1);
    queue_req(FUNC_INSERT, k, 1'b1);
    queue_req(FUNC_LOOKUP, k, 1'b0);
    queue_req(FUNC_INSERT, k, 1'b0);
    queue_req(FUNC_LOOKUP, k, 1'b1);
    // All-zero key, then colliding keys that differ only in the high halves
    k = '0;
    queue_req(FUNC_INSERT, k, 1'b1);
    queue_req(FUNC_LOOKUP, k, 1'b0);
    k.tile_x = 32'h0001_0000;
    queue_req(FUNC_LOOKUP, k, 1'b0);
    queue_req(FUNC_INSERT, k, 1'b0);
    queue_req(FUNC_LOOKUP, k, 1'b1);
    k = '{zoom: 5'd0, tile_x: 32'd0, tile_y: 32'h0001_0000};
    queue_req(FUNC_LOOKUP, k, 1'b0);
    queue_req(FUNC_INSERT, k, 1'b1);
    queue_req(FUNC_LOOKUP, k, 1'b0);
    // Same coordinates at another zoom
    k = '{zoom: 5'd1, tile_x: 32'd0, tile_y: 32'd0};
    queue_req(FUNC_INSERT, k, 1'b1);
    queue_req(FUNC_LOOKUP, k, 1'b0);

    // Random: mostly family traffic, which fills clusters to the probe limit
    total = ITEM_COUNT;
    while (pending_reqs.size() < total) begin
      r = $urandom_range(0, 99);
      rnd = $urandom;
      if (r < 35) begin
        queue_req(FUNC_INSERT, family_key($urandom_range(0, N_FAMILIES - 1)), rnd[0]);
      end else if (r < 70) begin
        // revisit a key already queued
        k = pending_reqs[$urandom_range(0, pending_reqs.size() - 1)].key;
        queue_req((r < 50) ? FUNC_INSERT : FUNC_LOOKUP, k, rnd[0]);
      end else if (r < 82) begin
        queue_req(FUNC_LOOKUP, family_key($urandom_range(0, N_FAMILIES - 1)), rnd[0]);
      end else begin
        k.zoom = 5'($urandom_range(0, 31));
        k.tile_x = $urandom;
        k.tile_y = $urandom;
        queue_req((r < 92) ? FUNC_INSERT : FUNC_LOOKUP, k, rnd[0]);
      end
    end

    // Synchronous reset, then let the block clear its table
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_sent != total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d lookup hits, %0d lookup misses,", items_sent, n_hits,
             n_misses);
    $display("%0d inserts written and %0d inserts dropped; %0d errors.", n_written, n_dropped,
             fail_count);
    if (fail_count == 0) begin
      $display("tile_key_linear_probe_table: match");
    end else begin
      $display("tile_key_linear_probe_table: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tile_key_linear_probe_table: mismatch");
    $finish;
  end

endmodule
